// File: hdl/rmmw_pkg.sv
// Package for the running mean/median window block.
// Holds sizes, reset constants and the sequencer state type; no dependencies.
package rmmw_pkg;
  localparam int unsigned DepthDefault     = 128;
  localparam int unsigned SampleW          = 16;
  localparam int unsigned CountW           = 8;
  localparam int unsigned SumW             = 24;
  localparam int unsigned LimitW           = 7;
  localparam logic [6:0]  ClearLimitReset  = 7'd100;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_MED0,
    ST_MED1,
    ST_DIV,
    ST_DONE
  } state_t;
endpackage

// File: hdl/rmmw_if.sv
// Valid/ready channel interfaces for the running mean/median window block.
// Field widths are written as literals; no package dependency.
interface rmmw_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface rmmw_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         sample_count;
  logic signed [15:0] mean_value;
  logic signed [15:0] median_value;
  modport source (output valid, output sample_count, output mean_value,
                  output median_value, input ready);
  modport sink (input valid, input sample_count, input mean_value,
                input median_value, output ready);
endinterface

interface rmmw_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] clear_limit;
  modport source (output valid, output clear_limit, input ready);
  modport sink (input valid, input clear_limit, output ready);
endinterface

// File: hdl/running_mean_median_window_top.sv
// Running mean/median window: top level with sorted store and sequencer.
// Depends on rmmw_pkg and the channel interfaces in rmmw_if.sv.
//
// Usage: one signed Q8.8 sample per transfer on in_ch; one result
// (count, mean, median) per sample on out_ch; clear_limit on cfg_ch,
// written while idle. in_ch is ready only in the idle state with no result held.
// Sequence per item: the insertion scan walks the store from the top,
// one entry per cycle through the single store read port, then a write
// state stores the sample, the states MED0 and MED1 read the median
// entries, a restoring divider resolves one quotient bit per cycle, and
// the DONE state loads the result. The result sits in an output
// register; the block accepts the next sample the cycle after that
// result transfers, so it takes no new sample before it is through with
// the last, and a stalled receiver holds the block. Reset clears count,
// sum and limit (to 100); the store itself is not cleared, since only
// entries below the count are read.
module running_mean_median_window_top #(
  parameter int unsigned DEPTH = rmmw_pkg::DepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  rmmw_in_if.sink     in_ch,
  rmmw_out_if.source  out_ch,
  rmmw_cfg_if.sink    cfg_ch
);
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned SW = rmmw_pkg::SumW;

  rmmw_pkg::state_t state, state_next;

  logic signed [15:0] mem [DEPTH];
  logic signed [15:0] rd_data;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic signed [15:0] wr_data;

  logic [6:0]         clear_limit;
  logic [8:0]         held_count;
  logic signed [SW-1:0] running_sum;
  logic signed [15:0] sample;
  logic [8:0]         pos;
  logic               rd_pending;
  logic signed [15:0] med_a;
  logic [SW-1:0]      quo;
  logic [SW:0]        rem;
  logic [4:0]         div_cnt;
  logic               neg;
  logic [7:0]         out_count;
  logic signed [15:0] out_mean;
  logic signed [15:0] out_median;
  logic               out_valid;

  logic               clear_now;
  logic [8:0]         start_count;
  logic [SW:0]        rem_shift;
  logic signed [16:0] med_sum;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state == rmmw_pkg::ST_IDLE) && !out_valid;
  assign out_ch.valid = out_valid;
  assign out_ch.sample_count = out_count;
  assign out_ch.mean_value   = out_mean;
  assign out_ch.median_value = out_median;

  assign clear_now = (held_count > {2'b0, clear_limit}) || (32'(held_count) >= DEPTH);
  assign start_count = clear_now ? 9'd0 : held_count;
  assign rem_shift = {rem[SW-1:0], quo[SW-1]};
  assign med_sum = 17'(med_a) + 17'(rd_data);

  // store: one write port, registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) state <= rmmw_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // next state, store port control
  always_comb begin
    state_next = state;
    rd_addr = '0;
    wr_en = 1'b0;
    wr_addr = '0;
    wr_data = rd_data;
    case (state)
      rmmw_pkg::ST_IDLE: begin
        if (in_ch.valid && in_ch.ready) state_next = rmmw_pkg::ST_SCAN;
        rd_addr = AW'(start_count - 9'd1);
      end
      rmmw_pkg::ST_SCAN: begin
        rd_addr = AW'(pos - 9'd2);
        if (pos == 9'd0) begin
          state_next = rmmw_pkg::ST_WRITE;
        end else if (rd_pending) begin
          if (rd_data > sample) begin
            wr_en = 1'b1;
            wr_addr = AW'(pos);
          end else begin
            state_next = rmmw_pkg::ST_WRITE;
          end
        end
      end
      rmmw_pkg::ST_WRITE: begin
        wr_en = 1'b1;
        wr_addr = AW'(pos);
        wr_data = sample;
        state_next = rmmw_pkg::ST_MED0;
      end
      rmmw_pkg::ST_MED0: begin
        rd_addr = AW'(held_count >> 1);
        state_next = rmmw_pkg::ST_MED1;
      end
      rmmw_pkg::ST_MED1: begin
        rd_addr = AW'((held_count >> 1) - 9'd1);
        state_next = rmmw_pkg::ST_DIV;
      end
      rmmw_pkg::ST_DIV: begin
        if (div_cnt == 5'(SW - 1)) state_next = rmmw_pkg::ST_DONE;
      end
      rmmw_pkg::ST_DONE: state_next = rmmw_pkg::ST_IDLE;
      default: state_next = rmmw_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_limit <= rmmw_pkg::ClearLimitReset;
      held_count  <= '0;
      running_sum <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) clear_limit <= cfg_ch.clear_limit;
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      if (in_ch.valid && in_ch.ready) begin
        held_count  <= start_count + 9'd1;
        running_sum <= (clear_now ? SW'(0) : running_sum) + SW'(in_ch.sample);
      end
      if (state == rmmw_pkg::ST_DONE) out_valid <= 1'b1;
    end
  end

  // datapath: scan position, median, serial divider
  always_ff @(posedge clk) begin
    case (state)
      rmmw_pkg::ST_IDLE: begin
        sample <= in_ch.sample;
        pos <= start_count;
        rd_pending <= (start_count != 9'd0);
      end
      rmmw_pkg::ST_SCAN: begin
        if (rd_pending && pos != 9'd0 && rd_data > sample) begin
          pos <= pos - 9'd1;
          rd_pending <= (pos != 9'd1);
        end
      end
      rmmw_pkg::ST_WRITE: begin
        neg <= running_sum[SW-1];
        quo <= running_sum[SW-1] ? SW'(-running_sum) : SW'(running_sum);
        rem <= '0;
        div_cnt <= '0;
      end
      rmmw_pkg::ST_MED1: begin
        med_a <= rd_data;
      end
      rmmw_pkg::ST_DIV: begin
        if (div_cnt == 5'd0) begin
          // median ready: second read lands on first divide cycle
          if (held_count[0]) out_median <= med_a;
          else out_median <= 16'(med_sum >>> 1);
        end
        // restore one quotient bit per cycle
        if (rem_shift >= (SW+1)'(held_count)) begin
          rem <= rem_shift - (SW+1)'(held_count);
          quo <= {quo[SW-2:0], 1'b1};
        end else begin
          rem <= rem_shift;
          quo <= {quo[SW-2:0], 1'b0};
        end
        div_cnt <= div_cnt + 5'd1;
      end
      rmmw_pkg::ST_DONE: begin
        out_count <= held_count[7:0];
        out_mean <= neg ? 16'(-quo) : 16'(quo);
      end
      default: ;
    endcase
  end
endmodule

// File: hdl/rmmw_checker.sv
// Port-level checker for the running mean/median window block.
// Takes the top level's channel signals as plain ports; bound to the top level.
module rmmw_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_count
);
  // a sample is never taken while a result waits
  a_no_accept_pending: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input ready while result held");
  // no result right after an accept
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !out_valid) else $error("result too early");
  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(out_count))
    else $error("stalled result changed");
  // count never zero
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_count != 8'd0) else $error("zero count");
endmodule

bind running_mean_median_window_top rmmw_checker u_rmmw_checker (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_count(out_ch.sample_count)
);
